### src/tfuv_pkg.sv
// Package: shared item types, register codes and defaults for the text field validator.
package tfuv_pkg;

    // Counter width default for the field byte count
    localparam int LENGTH_BITS_DEFAULT = 16;

    // Configuration port geometry
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_ENABLE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH   = 1'd1;

    // Configuration reset values
    localparam logic        CHECK_ENABLE_RESET = 1'b1;
    localparam logic [15:0] MAX_LENGTH_RESET   = 16'd1024;

    // Reject reason codes
    localparam logic [1:0] REASON_OK       = 2'd0;
    localparam logic [1:0] REASON_TOO_LONG = 2'd1;
    localparam logic [1:0] REASON_BAD_UTF8 = 2'd2;
    localparam logic [1:0] REASON_CONTROL  = 2'd3;

    // One input item: a field byte or the end marker
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_field;
    } t_in_item;

    // One result item: the verdict for a completed field
    typedef struct packed {
        logic       field_ok;
        logic [1:0] reject_reason;
    } t_out_item;

    // Live configuration seen by the checker
    typedef struct packed {
        logic        check_enable;
        logic [15:0] max_length;
    } t_cfg;

endpackage

### src/tfuv_cfg_regs.sv
// Configuration registers: check enable and maximum field length.
module tfuv_cfg_regs
    import tfuv_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write into the addressed register
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CHECK_ENABLE: n_cfg.check_enable = i_cfg_data[0];
                CFG_MAX_LENGTH:   n_cfg.max_length   = i_cfg_data[15:0];
                default:          n_cfg              = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.check_enable <= CHECK_ENABLE_RESET;
            r_cfg.max_length   <= MAX_LENGTH_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/tfuv_field_check.sv
// Per-field state: length count, UTF-8 sequence tracking, control byte flag and verdict.
module tfuv_field_check
    import tfuv_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_take,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output logic      o_res_valid,
    output t_out_item o_res_item
);

    localparam int CMP_W = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    logic [LENGTH_BITS-1:0] r_byte_count, n_byte_count;
    logic [1:0]             r_pending, n_pending;
    logic                   r_too_long, n_too_long;
    logic                   r_bad_enc, n_bad_enc;
    logic                   r_ctrl, n_ctrl;

    logic             cnt_sat;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] max_ext;
    logic [7:0]       b;
    logic [1:0]       reason;

    assign b       = i_item.data_byte;
    assign cnt_sat = (r_byte_count == {LENGTH_BITS{1'b1}});
    assign cnt_ext = CMP_W'(r_byte_count);
    assign max_ext = CMP_W'(i_cfg.max_length);

    // Advance the field state on a byte, clear it on the end marker
    always_comb begin
        n_byte_count = r_byte_count;
        n_pending    = r_pending;
        n_too_long   = r_too_long;
        n_bad_enc    = r_bad_enc;
        n_ctrl       = r_ctrl;
        if (i_take) begin
            if (i_item.end_of_field) begin
                n_byte_count = '0;
                n_pending    = '0;
                n_too_long   = 1'b0;
                n_bad_enc    = 1'b0;
                n_ctrl       = 1'b0;
            end else begin
                // length
                if (cnt_ext >= max_ext || cnt_sat) begin
                    n_too_long = 1'b1;
                end
                if (!cnt_sat) begin
                    n_byte_count = r_byte_count + LENGTH_BITS'(1);
                end
                // structure
                if (r_pending != 2'd0) begin
                    if (b[7:6] == CONT_TAG) begin
                        n_pending = r_pending - 2'd1;
                    end else begin
                        n_bad_enc = 1'b1;
                        n_pending = 2'd0;
                    end
                end else if (!b[7]) begin
                    n_pending = 2'd0;
                end else if (b[7:5] == LEAD2_TAG) begin
                    n_pending = 2'd1;
                end else if (b[7:4] == LEAD3_TAG) begin
                    n_pending = 2'd2;
                end else if (b[7:3] == LEAD4_TAG) begin
                    n_pending = 2'd3;
                end else begin
                    n_bad_enc = 1'b1;
                end
                // control bytes other than tab, LF and CR
                if (b < CTRL_LIMIT && b != CHAR_TAB && b != CHAR_LF && b != CHAR_CR) begin
                    n_ctrl = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_pending    <= '0;
            r_too_long   <= 1'b0;
            r_bad_enc    <= 1'b0;
            r_ctrl       <= 1'b0;
        end else begin
            r_byte_count <= n_byte_count;
            r_pending    <= n_pending;
            r_too_long   <= n_too_long;
            r_bad_enc    <= n_bad_enc;
            r_ctrl       <= n_ctrl;
        end
    end

    // Pick the first failing reason in priority order
    always_comb begin
        reason = REASON_OK;
        if (i_cfg.check_enable) begin
            if (r_too_long) begin
                reason = REASON_TOO_LONG;
            end else if (r_bad_enc || r_pending != 2'd0) begin
                reason = REASON_BAD_UTF8;
            end else if (r_ctrl) begin
                reason = REASON_CONTROL;
            end
        end
    end

    assign o_res_valid              = i_take && i_item.end_of_field;
    assign o_res_item.field_ok      = (reason == REASON_OK);
    assign o_res_item.reject_reason = reason;

    // End marker leaves a clean state for the next field
    a_clear_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_item.end_of_field |=>
            r_byte_count == '0 && r_pending == 2'd0 && !r_too_long && !r_bad_enc && !r_ctrl)
        else $error("field state not cleared after end marker");

    // A byte taken at the saturated count marks the field too long
    a_sat_too_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && !i_item.end_of_field && cnt_sat |=> r_too_long && cnt_sat)
        else $error("saturated count did not flag too long");

    // A byte never leaves the count unchanged unless it is saturated
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && !i_item.end_of_field && !cnt_sat |=>
            r_byte_count == $past(r_byte_count) + LENGTH_BITS'(1))
        else $error("byte count did not advance");

endmodule

### src/tfuv_out_stage.sv
// Result register between the checker and the output channel.
module tfuv_out_stage
    import tfuv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_res_valid,
    input  t_out_item i_res_item,
    input  logic      i_out_stall,
    output logic      o_full_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    logic      r_valid, n_valid;
    t_out_item r_item, n_item;

    // Hold upstream only while a result waits on a stalled consumer
    assign o_full_stall = r_valid && i_out_stall;

    // Load a new verdict, drop a delivered one, hold otherwise
    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (i_res_valid) begin
            n_valid = 1'b1;
            n_item  = i_res_item;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    // A verdict never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_out_stall |-> !i_res_valid)
        else $error("result overwritten while stalled");

    // field_ok agrees with the reason code
    a_ok_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_item.field_ok == (r_item.reject_reason == REASON_OK)))
        else $error("field_ok disagrees with reject_reason");

endmodule

### src/text_field_utf8_validator_core.sv
// Top level of the text field validator: config registers, field checker, result register.
//
// Checks text fields streamed one byte per item and closed by an end marker item.
// Each byte updates the length count, the UTF-8 sequence tracker and the control byte
// flag, and an end marker produces its verdict in the result register in the cycle
// after it is accepted, clearing the field state at the same edge. Items may arrive
// in every cycle; the input stalls only while a verdict sits in the result register
// and the consumer stalls it. Data bytes produce no result. The verdict gives the
// first failing reason: too long, bad UTF-8 (including a sequence cut short by the
// end marker), then a control byte other than tab, LF or CR. With check_enable at 0
// every field passes. Write the configuration only while no field is in progress and
// no verdict is pending.
module text_field_utf8_validator_core
    import tfuv_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_item               i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_item              o_out_item,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg      cfg;
    logic      take;
    logic      res_valid;
    t_out_item res_item;

    assign take = i_in_valid && !o_in_stall;

    tfuv_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tfuv_field_check #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_item      (i_in_item),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res_item  (res_item)
    );

    tfuv_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_res_valid  (res_valid),
        .i_res_item   (res_item),
        .i_out_stall  (i_out_stall),
        .o_full_stall (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_out_item   (o_out_item)
    );

endmodule
